// ===== src/dmqs_pkg.sv =====
// dmqs_pkg: shared types and constants for the dual mode queue/stack block.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package dmqs_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [1:0] CMD_ADD      = 2'd0;
   localparam logic [1:0] CMD_REMOVE   = 2'd1;
   localparam logic [1:0] CMD_SET_MODE = 2'd2;

   localparam logic [1:0] MODE_QUEUE = 2'd0;
   localparam logic [1:0] MODE_STACK = 2'd1;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] item_value;
      logic [1:0]         new_mode;
   } req_type;

   typedef struct packed {
      logic               status;
      logic signed [31:0] removed_value;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic load;
   } ctrl_cmd_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage
`default_nettype wire

// ===== src/dual_mode_queue_stack_top.sv =====
// dual_mode_queue_stack_top: ring store acting as a FIFO queue or LIFO stack.
// Use: send one beat on req_ (command, item_value, new_mode); one rsp_ beat
// (status, removed_value) comes back for each. Commands: add, remove, set mode.
// Set mode works only on an empty store; modes 2 and 3 make add and remove fail.
// rsp_valid is registered: it rises when the result register is loaded on leaving ST_EXEC.
// The block takes no new request beat until the previous one has left ST_EXEC;
// req_stall is high in the cycle after each accept.
// An unread result sits in the output register while the next request is taken;
// if rsp_stall holds it, the following result waits and req_stall stays high.
// Reset (synchronous, active high) empties the store, selects queue mode, sets
// the front index to 0 and the rear index to DEPTH-1, and drops rsp_valid.
// The store contents are not cleared; no clearing pass runs after reset.
// Depends on dmqs_pkg, dmqs_ctrl and dmqs_dp.
`default_nettype none
module dual_mode_queue_stack_top
   import dmqs_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;

   dmqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dmqs_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== src/dmqs_ctrl.sv =====
// dmqs_ctrl: handshake state machine and result valid register.
// Depends on dmqs_pkg; drives the datapath through ctrl_cmd_type.
`default_nettype none
module dmqs_ctrl
   import dmqs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.accept = 1'b0;
      cmd.load   = 1'b0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_EXEC: begin
            cmd.load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && $past(state_ff) == ST_IDLE) |-> $past(cmd.accept))
      else $error("exec entered without an accepted beat");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("loaded result not presented");
   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && rsp_valid_ff && rsp_stall) |=> state_ff == ST_EXEC)
      else $error("result dropped while output stalled");
`endif

endmodule
`default_nettype wire

// ===== src/dmqs_dp.sv =====
// dmqs_dp: ring store, front/rear indices, count, mode and result register.
// Depends on dmqs_pkg; steered by dmqs_ctrl through ctrl_cmd_type.
`default_nettype none
module dmqs_dp
   import dmqs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  ctrl_cmd_type cmd,
   input  req_type      req_data,
   output rsp_type      rsp_data
);

   logic [31:0]      mem [DEPTH];
   logic [IDX_W-1:0] front_ff;
   logic [IDX_W-1:0] front_in;
   logic [IDX_W-1:0] rear_ff;
   logic [IDX_W-1:0] rear_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [1:0]       mode_ff;
   logic [1:0]       mode_in;
   logic [31:0]      rd_data_ff;
   logic             status_ff;
   logic             status_in;
   logic             pop_ok_ff;
   rsp_type          rsp_ff;

   logic             valid_mode;
   logic             add_ok;
   logic             pop_ok;
   logic             set_ok;
   logic [IDX_W-1:0] rear_next;
   logic [IDX_W-1:0] rear_prev;
   logic [IDX_W-1:0] front_next;
   logic [IDX_W-1:0] rd_addr;

   assign valid_mode = (mode_ff == MODE_QUEUE) || (mode_ff == MODE_STACK);
   assign add_ok = (req_data.command == CMD_ADD) && (count_ff != CNT_W'(DEPTH))
                   && valid_mode;
   assign pop_ok = (req_data.command == CMD_REMOVE) && (count_ff != '0) && valid_mode;
   assign set_ok = (req_data.command == CMD_SET_MODE) && (count_ff == '0);

   assign rear_next  = (rear_ff == IDX_W'(DEPTH - 1)) ? '0 : rear_ff + 1'b1;
   assign rear_prev  = (rear_ff == '0) ? IDX_W'(DEPTH - 1) : rear_ff - 1'b1;
   assign front_next = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign rd_addr    = (mode_ff == MODE_QUEUE) ? front_ff : rear_ff;

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      count_in  = count_ff;
      mode_in   = mode_ff;
      status_in = !(add_ok || pop_ok || set_ok);
      if (add_ok) begin
         rear_in  = rear_next;
         count_in = count_ff + 1'b1;
      end else if (pop_ok) begin
         count_in = count_ff - 1'b1;
         if (mode_ff == MODE_QUEUE) begin
            front_in = front_next;
         end else begin
            rear_in = rear_prev;
         end
      end else if (set_ok) begin
         mode_in  = req_data.new_mode;
         front_in = '0;
         rear_in  = IDX_W'(DEPTH - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= IDX_W'(DEPTH - 1);
         count_ff <= '0;
         mode_ff  <= MODE_QUEUE;
      end else if (cmd.accept) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && add_ok) begin
         mem[rear_next] <= req_data.item_value;
      end
      if (cmd.accept) begin
         rd_data_ff <= mem[rd_addr];
         status_ff  <= status_in;
         pop_ok_ff  <= pop_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.removed_value <= pop_ok_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("item count beyond depth");
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_data.command == CMD_REMOVE && count_ff == '0)
      |=> ($stable(count_ff) && $stable(front_ff) && $stable(rear_ff)))
      else $error("remove on empty store changed state");
   a_busy_mode: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_data.command == CMD_SET_MODE && count_ff != '0)
      |=> $stable(mode_ff))
      else $error("mode changed on nonempty store");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: random and directed test of dual_mode_queue_stack_top (FIFO and LIFO ring store).
// Drives req_ beats from a pending queue, predicts each rsp_ beat, and checks it field by field.
// Depends on dmqs_pkg and dual_mode_queue_stack_top.
module tb_top;
   import dmqs_pkg::*;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam logic [1:0] MODE_INVALID_A = 2'd2;
   localparam logic [1:0] MODE_INVALID_B = 2'd3;
   localparam int         CYCLE_LIMIT    = 200000;
   localparam int         LONG_HOLD      = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pend_q[$];
   rsp_type expected_q[$];

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit send_hold = 1'b0;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int err_count = 0;
   int checked_count = 0;
   int cycle_count = 0;

   // shadow of the block, updated on every accepted beat
   logic signed [31:0] slot[DEPTH];
   logic [IDX_W-1:0]   front_idx;
   logic [IDX_W-1:0]   rear_idx;
   int                 held;
   logic [1:0]         cur_mode;
   int n_add = 0, n_remove = 0, n_full = 0, n_empty = 0, n_mode = 0;

   // generator-side tracking of occupancy and mode
   int         gen_count = 0;
   logic [1:0] gen_mode = MODE_QUEUE;
   int         pend_pushed = 0;

   dual_mode_queue_stack_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic rsp_type predict_result(input req_type r);
      rsp_type res;
      logic    mode_ok;
      res.status = 1'b1;
      res.removed_value = '0;
      mode_ok = (cur_mode == MODE_QUEUE) || (cur_mode == MODE_STACK);
      case (r.command)
         CMD_ADD: begin
            if (held < DEPTH && mode_ok) begin
               rear_idx = (rear_idx == IDX_W'(DEPTH - 1)) ? '0 : rear_idx + 1'b1;
               slot[rear_idx] = r.item_value;
               held++;
               n_add++;
               res.status = 1'b0;
            end else if (held == DEPTH) begin
               n_full++;
            end
         end
         CMD_REMOVE: begin
            if (held != 0 && mode_ok) begin
               if (cur_mode == MODE_QUEUE) begin
                  res.removed_value = slot[front_idx];
                  front_idx = (front_idx == IDX_W'(DEPTH - 1)) ? '0 : front_idx + 1'b1;
               end else begin
                  res.removed_value = slot[rear_idx];
                  rear_idx = (rear_idx == '0) ? IDX_W'(DEPTH - 1) : rear_idx - 1'b1;
               end
               held--;
               n_remove++;
               res.status = 1'b0;
            end else if (held == 0) begin
               n_empty++;
            end
         end
         CMD_SET_MODE: begin
            if (held == 0) begin
               cur_mode = r.new_mode;
               front_idx = '0;
               rear_idx = IDX_W'(DEPTH - 1);
               n_mode++;
               res.status = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(15))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_item(input logic [1:0] cmd, input logic signed [31:0] value,
                             input logic [1:0] mode);
      req_type r;
      logic    ok;
      r.command = cmd;
      r.item_value = value;
      r.new_mode = mode;
      pend_q.push_back(r);
      pend_pushed++;
      ok = (gen_mode == MODE_QUEUE) || (gen_mode == MODE_STACK);
      if (cmd == CMD_ADD && ok && gen_count < DEPTH)
         gen_count++;
      else if (cmd == CMD_REMOVE && ok && gen_count > 0)
         gen_count--;
      else if (cmd == CMD_SET_MODE && gen_count == 0)
         gen_mode = mode;
   endtask

   task automatic build_random(input int total);
      int stop;
      int kind;
      int len;
      stop = pend_pushed + total;
      while (pend_pushed < stop) begin
         kind = $urandom_range(99);
         len = 8 + $urandom_range(16);
         if (kind < 35) begin
            repeat (len)
               queue_item(($urandom_range(99) < 80) ? CMD_ADD : CMD_REMOVE, pick_value(),
                          2'($urandom_range(3)));
         end else if (kind < 62) begin
            repeat (len)
               queue_item(($urandom_range(99) < 80) ? CMD_REMOVE : CMD_ADD, pick_value(),
                          2'($urandom_range(3)));
         end else if (kind < 75) begin
            repeat (len)
               queue_item($urandom_range(1) ? CMD_REMOVE : CMD_ADD, pick_value(),
                          2'($urandom_range(3)));
         end else if (kind < 92) begin
            while (gen_count > 0)
               queue_item(CMD_REMOVE, pick_value(), 2'($urandom_range(3)));
            if ($urandom_range(99) < 85) begin
               queue_item(CMD_SET_MODE, pick_value(),
                          $urandom_range(1) ? MODE_STACK : MODE_QUEUE);
            end else begin
               queue_item(CMD_SET_MODE, pick_value(),
                          $urandom_range(1) ? MODE_INVALID_B : MODE_INVALID_A);
               repeat (1 + $urandom_range(2))
                  queue_item($urandom_range(1) ? CMD_REMOVE : CMD_ADD, pick_value(),
                             2'($urandom_range(3)));
               queue_item(CMD_SET_MODE, pick_value(),
                          $urandom_range(1) ? MODE_STACK : MODE_QUEUE);
            end
         end else begin
            repeat (4)
               queue_item(2'($urandom_range(3)), pick_value(), 2'($urandom_range(3)));
         end
      end
   endtask

   task automatic wait_drained();
      while (pend_q.size() != 0 || req_valid || expected_q.size() != 0)
         @(posedge clock);
   endtask

   // driver: predict on each accepted beat, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         front_idx = '0;
         rear_idx = IDX_W'(DEPTH - 1);
         held = 0;
         cur_mode = MODE_QUEUE;
      end else begin
         if (req_valid && !req_stall)
            expected_q.push_back(predict_result(req_data));
         if (!req_valid || !req_stall) begin
            if (pend_q.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pend_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted rsp beat and drive the receiver stall
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("unexpected rsp beat: status %0b removed_value %0d",
                   rsp_data.status, rsp_data.removed_value);
            err_count++;
         end else begin
            want = expected_q.pop_front();
            checked_count++;
            if (rsp_data.status !== want.status) begin
               $error("status mismatch: expected %0b, actual %0b",
                      want.status, rsp_data.status);
               err_count++;
            end
            if (rsp_data.removed_value !== want.removed_value) begin
               $error("removed_value mismatch: expected %0d, actual %0d",
                      want.removed_value, rsp_data.removed_value);
               err_count++;
            end
         end
      end
      if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      send_idle_pct = 16;
      rsp_idle_pct = 87;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, extremes, FIFO order, LIFO order, invalid modes, unused code
      queue_item(CMD_REMOVE, 32'sd7, MODE_QUEUE);
      queue_item(CMD_ADD, 32'sh7FFF_FFFF, MODE_INVALID_B);
      queue_item(CMD_ADD, 32'sh8000_0000, MODE_QUEUE);
      queue_item(CMD_ADD, '0, MODE_STACK);
      queue_item(CMD_ADD, '1, MODE_INVALID_A);
      queue_item(CMD_SET_MODE, '0, MODE_STACK);
      repeat (4) queue_item(CMD_REMOVE, '1, MODE_INVALID_B);
      queue_item(CMD_UNUSED, 32'sh5A5A_A5A5, MODE_INVALID_B);
      queue_item(CMD_SET_MODE, '1, MODE_STACK);
      queue_item(CMD_ADD, 32'sd5, MODE_QUEUE);
      queue_item(CMD_ADD, -32'sd6, MODE_QUEUE);
      queue_item(CMD_REMOVE, '0, MODE_QUEUE);
      queue_item(CMD_REMOVE, '0, MODE_QUEUE);
      queue_item(CMD_REMOVE, '0, MODE_QUEUE);
      queue_item(CMD_SET_MODE, '0, MODE_INVALID_A);
      queue_item(CMD_ADD, 32'sd9, MODE_QUEUE);
      queue_item(CMD_REMOVE, '0, MODE_QUEUE);
      queue_item(CMD_SET_MODE, '0, MODE_INVALID_B);
      queue_item(CMD_SET_MODE, '0, MODE_QUEUE);

      build_random(300);
      wait_drained();

      send_idle_pct = 87;
      rsp_idle_pct = 16;
      build_random(150);
      while (pend_q.size() != 0) @(posedge clock);
      send_hold = 1'b1;
      while (req_valid || expected_q.size() != 0) @(posedge clock);
      send_hold = 1'b0;
      build_random(150);
      wait_drained();

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_trigger++;
      build_random(200);
      wait_drained();
      repeat (8) @(posedge clock);

      $display("%0d rsp beats checked: %0d adds and %0d removes done, %0d mode changes,",
               checked_count, n_add, n_remove, n_mode);
      $display("%0d adds refused on a full store, %0d removes on an empty one",
               n_full, n_empty);
      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/dmqs_pkg.sv
src/dmqs_ctrl.sv
src/dmqs_dp.sv
src/dual_mode_queue_stack_top.sv
test/tb_top.sv
